// ===== hdl/ffha_pkg.sv =====
// Shared constants, opcodes and sequencer states of the first-fit heap allocator.
package ffha_pkg;

   localparam int HEAP_BYTES_DEF   = 16384;
   localparam int HEADER_BYTES_DEF = 20;

   // Fixed field widths of the channels.
   localparam int REQ_W   = 15;
   localparam int ADDR_W  = 14;
   localparam int COPY_W  = 15;
   localparam int CFG_W   = 15;
   // Header plus a 15-bit request rounded up to four.
   localparam int NEED_W  = 17;

   localparam logic [CFG_W-1:0] HEAP_SIZE_RST = 15'd16384;

   localparam logic [1:0] OP_ALLOC   = 2'd0;
   localparam logic [1:0] OP_FREE    = 2'd1;
   localparam logic [1:0] OP_REALLOC = 2'd2;
   localparam logic [1:0] OP_CLEAR   = 2'd3;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_WALK,
      ST_WCHK,
      ST_UL_RD,
      ST_UL_GOT,
      ST_UL_N,
      ST_UL_NW,
      ST_UL_P,
      ST_UL_PW,
      ST_UL_B,
      ST_SPLIT,
      ST_SPL_B,
      ST_SPL_NW,
      ST_PU,
      ST_PU_H,
      ST_PU_B,
      ST_TDONE,
      ST_COPY,
      ST_LIVE,
      ST_LCHK,
      ST_RCMP,
      ST_R_RD,
      ST_R_ST,
      ST_R_P,
      ST_R_N0,
      ST_R_N,
      ST_R_NN0,
      ST_R_NNW,
      ST_R_PU,
      ST_CLR,
      ST_CLR_END,
      ST_DONE
   } state_type;

endpackage

// ===== hdl/ffha_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ffha_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== hdl/first_fit_heap_allocator.sv =====
// First-fit heap allocator: one sequencer over two block-descriptor RAMs and a shared adder.
//
// Usage: each request transaction on req_ carries an opcode in req_tuser and the
// request size and block offset in req_tdata. Exactly one response transaction
// follows on rsp_ with the granted offset, a status bit and the byte count to copy.
// The csr_ port writes the heap size, which only a clear operation uses.
// One request is worked at a time; req_tready is high only while idle.
// Every table access is a RAM read with a registered result: allocate visits
// free-list blocks until one fits, then unlinks, splits, pushes and responds;
// freeing a live block merges it with any free neighbors, and a rejected free
// only checks the block; reallocate in place only compares sizes, a moving one adds
// both. A clear sweeps the whole descriptor table, one entry per cycle.
// Reset empties the free list and sets the heap size to 16384 bytes; the heap must
// be cleared before the first allocation. The finished response waits in an
// output register, so the block returns to idle and takes the next request while
// the receiver stalls; the following response then waits until that one is taken.
module first_fit_heap_allocator #(
   parameter int HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
   parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // request_bytes [14:0], block_address [28:15], zero [31:29]
   input  logic [31:0]                 req_tdata,
   // opcode [1:0]
   input  logic [1:0]                  req_tuser,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // address [13:0], status [14], copy_bytes [29:15], zero [31:30]
   output logic [31:0]                 rsp_tdata,
   input  logic                        csr_wr_en,
   input  logic [ffha_pkg::CFG_W-1:0]  csr_wr_data
);

   import ffha_pkg::*;

   localparam int DEPTH = HEAP_BYTES / 4;
   localparam int IW    = $clog2(DEPTH);
   localparam int PW    = $clog2(DEPTH + 1);
   localparam int SW    = $clog2(HEAP_BYTES) + 1;
   localparam int AW    = ((SW > NEED_W) ? SW : NEED_W) + 1;
   localparam logic [PW-1:0] NIL = PW'(DEPTH);

   typedef struct packed {
      logic [SW-1:0] size;
      logic          busy;
      logic [PW-1:0] nphys;
      logic [PW-1:0] pphys;
   } phys_type;

   typedef struct packed {
      logic [PW-1:0] next;
      logic [PW-1:0] prev;
   } link_type;

   function automatic logic ptr_ok(input logic [PW-1:0] p);
      return p < NIL;
   endfunction

   state_type state_ff, state_in, ret_ff, ret_in;
   logic [1:0]        op_ff, op_in;
   logic [NEED_W-1:0] need_ff, need_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [PW-1:0]     b_ff, b_in, steps_ff, steps_in, s_ff, s_in;
   logic [PW-1:0]     u_b_ff, u_b_in, u_n_ff, u_n_in, u_p_ff, u_p_in;
   logic [PW-1:0]     head_ff, head_in, old_ff, old_in, cur_ff, cur_in;
   logic [PW-1:0]     rp_ff, rp_in, rn_ff, rn_in, rnn_ff, rnn_in;
   logic [IW-1:0]     clr_ff, clr_in;
   logic [SW-1:0]     extra_ff, extra_in;
   phys_type          bent_ff, bent_in, oent_ff, oent_in, cent_ff, cent_in;
   logic [ADDR_W-1:0] res_addr_ff, res_addr_in, rsp_addr_ff, rsp_addr_in;
   logic              res_status_ff, res_status_in, rsp_status_ff, rsp_status_in;
   logic [COPY_W-1:0] res_copy_ff, res_copy_in, rsp_copy_ff, rsp_copy_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CFG_W-1:0]  heap_size_ff;

   logic [AW-1:0] alu_a, alu_b, alu_res;
   logic          alu_sub;
   logic [31:0]   clr_sz;

   logic          phys_we, links_we;
   logic [PW-1:0] phys_wa, phys_ra, links_wa, links_ra;
   phys_type      phys_wd, phys_rd;
   link_type      links_wd, links_rd;

   ffha_ram #(.WIDTH($bits(phys_type)), .DEPTH(DEPTH)) u_phys_ram (
      .clock   (clock),
      .wr_en   (phys_we),
      .wr_addr (phys_wa[IW-1:0]),
      .wr_data (phys_wd),
      .rd_addr (phys_ra[IW-1:0]),
      .rd_data (phys_rd)
   );

   ffha_ram #(.WIDTH($bits(link_type)), .DEPTH(DEPTH)) u_links_ram (
      .clock   (clock),
      .wr_en   (links_we),
      .wr_addr (links_wa[IW-1:0]),
      .wr_data (links_wd),
      .rd_addr (links_ra[IW-1:0]),
      .rd_data (links_rd)
   );

   // The adder/subtractor that the size and offset arithmetic of the sequencer shares.
   // Operands stay below 2**(AW-1), so the top bit of a difference is the borrow.
   assign alu_res = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);

   // Clear size: rounded down to four and clamped to the legal range.
   always_comb begin
      clr_sz = {17'd0, heap_size_ff & ~15'd3};
      if (clr_sz > 32'(HEAP_BYTES)) begin
         clr_sz = 32'(HEAP_BYTES);
      end
      if (clr_sz < 32'(2 * HEADER_BYTES + 4)) begin
         clr_sz = 32'(2 * HEADER_BYTES + 4);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_ff       <= ST_IDLE;
         head_ff      <= NIL;
         rsp_valid_ff <= 1'b0;
         heap_size_ff <= HEAP_SIZE_RST;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            heap_size_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      need_ff       <= need_in;
      addr_ff       <= addr_in;
      b_ff          <= b_in;
      steps_ff      <= steps_in;
      s_ff          <= s_in;
      u_b_ff        <= u_b_in;
      u_n_ff        <= u_n_in;
      u_p_ff        <= u_p_in;
      old_ff        <= old_in;
      cur_ff        <= cur_in;
      rp_ff         <= rp_in;
      rn_ff         <= rn_in;
      rnn_ff        <= rnn_in;
      clr_ff        <= clr_in;
      extra_ff      <= extra_in;
      bent_ff       <= bent_in;
      oent_ff       <= oent_in;
      cent_ff       <= cent_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
      res_copy_ff   <= res_copy_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_copy_ff   <= rsp_copy_in;
   end

   always_comb begin
      state_in      = state_ff;
      ret_in        = ret_ff;
      op_in         = op_ff;
      need_in       = need_ff;
      addr_in       = addr_ff;
      b_in          = b_ff;
      steps_in      = steps_ff;
      s_in          = s_ff;
      u_b_in        = u_b_ff;
      u_n_in        = u_n_ff;
      u_p_in        = u_p_ff;
      head_in       = head_ff;
      old_in        = old_ff;
      cur_in        = cur_ff;
      rp_in         = rp_ff;
      rn_in         = rn_ff;
      rnn_in        = rnn_ff;
      clr_in        = clr_ff;
      extra_in      = extra_ff;
      bent_in       = bent_ff;
      oent_in       = oent_ff;
      cent_in       = cent_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      res_copy_in   = res_copy_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      rsp_copy_in   = rsp_copy_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      req_tready    = 1'b0;
      alu_a         = '0;
      alu_b         = '0;
      alu_sub       = 1'b0;
      phys_we       = 1'b0;
      phys_wa       = '0;
      phys_wd       = '0;
      phys_ra       = '0;
      links_we      = 1'b0;
      links_wa      = '0;
      links_wd      = '0;
      links_ra      = '0;

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               op_in   = req_tuser;
               need_in = NEED_W'(HEADER_BYTES)
                       + ((NEED_W'(req_tdata[REQ_W-1:0]) + NEED_W'(3)) & ~NEED_W'(3));
               addr_in       = req_tdata[REQ_W+ADDR_W-1:REQ_W];
               res_addr_in   = '0;
               res_status_in = 1'b0;
               res_copy_in   = '0;
               case (req_tuser)
                  OP_ALLOC: begin
                     b_in     = head_ff;
                     steps_in = '0;
                     state_in = ST_WALK;
                  end
                  OP_FREE, OP_REALLOC: begin
                     state_in = ST_LIVE;
                  end
                  default: begin
                     clr_in   = '0;
                     state_in = ST_CLR;
                  end
               endcase
            end
         end

         ST_WALK: begin
            if (!ptr_ok(b_ff) || steps_ff == NIL) begin
               res_status_in = 1'b1;
               state_in      = ST_DONE;
            end else begin
               phys_ra  = b_ff;
               links_ra = b_ff;
               state_in = ST_WCHK;
            end
         end

         ST_WCHK: begin
            alu_a   = AW'(phys_rd.size);
            alu_b   = AW'(need_ff);
            alu_sub = 1'b1;
            if (!alu_res[AW-1]) begin
               bent_in  = phys_rd;
               extra_in = alu_res[SW-1:0];
               u_b_in   = b_ff;
               u_n_in   = links_rd.next;
               u_p_in   = links_rd.prev;
               ret_in   = ST_SPLIT;
               state_in = ST_UL_N;
            end else begin
               b_in     = links_rd.next;
               steps_in = steps_ff + PW'(1);
               state_in = ST_WALK;
            end
         end

         // Free-list unlink of u_b.
         ST_UL_RD: begin
            links_ra = u_b_ff;
            state_in = ST_UL_GOT;
         end

         ST_UL_GOT: begin
            u_n_in   = links_rd.next;
            u_p_in   = links_rd.prev;
            state_in = ST_UL_N;
         end

         ST_UL_N: begin
            if (ptr_ok(u_n_ff)) begin
               links_ra = u_n_ff;
               state_in = ST_UL_NW;
            end else begin
               state_in = ST_UL_P;
            end
         end

         ST_UL_NW: begin
            links_we = 1'b1;
            links_wa = u_n_ff;
            links_wd = '{next: links_rd.next, prev: u_p_ff};
            state_in = ST_UL_P;
         end

         ST_UL_P: begin
            if (ptr_ok(u_p_ff)) begin
               links_ra = u_p_ff;
               state_in = ST_UL_PW;
            end else begin
               head_in  = u_n_ff;
               state_in = ST_UL_B;
            end
         end

         ST_UL_PW: begin
            links_we = 1'b1;
            links_wa = u_p_ff;
            links_wd = '{next: u_n_ff, prev: links_rd.prev};
            state_in = ST_UL_B;
         end

         ST_UL_B: begin
            links_we = 1'b1;
            links_wa = u_b_ff;
            links_wd = '{next: NIL, prev: NIL};
            state_in = ret_ff;
         end

         // The chosen block is marked busy by ST_SPLIT or, on a split, by ST_SPL_B; a remainder
         // of two headers or more becomes a new free block right behind it.
         ST_SPLIT: begin
            alu_a = AW'(b_ff);
            alu_b = AW'(need_ff >> 2);
            phys_we = 1'b1;
            if (AW'(extra_ff) >= AW'(2 * HEADER_BYTES) && alu_res < AW'(DEPTH)) begin
               s_in     = alu_res[PW-1:0];
               phys_wa  = alu_res[PW-1:0];
               phys_wd  = '{size: extra_ff, busy: 1'b0, nphys: bent_ff.nphys, pphys: b_ff};
               state_in = ST_SPL_B;
            end else begin
               phys_wa  = b_ff;
               phys_wd  = '{size: bent_ff.size, busy: 1'b1, nphys: bent_ff.nphys,
                            pphys: bent_ff.pphys};
               state_in = ST_TDONE;
            end
         end

         ST_SPL_B: begin
            phys_we = 1'b1;
            phys_wa = b_ff;
            phys_wd = '{size: SW'(need_ff), busy: 1'b1, nphys: s_ff, pphys: bent_ff.pphys};
            if (ptr_ok(bent_ff.nphys)) begin
               phys_ra  = bent_ff.nphys;
               state_in = ST_SPL_NW;
            end else begin
               u_b_in   = s_ff;
               ret_in   = ST_TDONE;
               state_in = ST_PU;
            end
         end

         ST_SPL_NW: begin
            phys_we       = 1'b1;
            phys_wa       = bent_ff.nphys;
            phys_wd       = phys_rd;
            phys_wd.pphys = s_ff;
            u_b_in        = s_ff;
            ret_in        = ST_TDONE;
            state_in      = ST_PU;
         end

         // Free-list push of u_b at the head.
         ST_PU: begin
            if (ptr_ok(head_ff)) begin
               links_ra = head_ff;
               state_in = ST_PU_H;
            end else begin
               state_in = ST_PU_B;
            end
         end

         ST_PU_H: begin
            links_we = 1'b1;
            links_wa = head_ff;
            links_wd = '{next: links_rd.next, prev: u_b_ff};
            state_in = ST_PU_B;
         end

         ST_PU_B: begin
            links_we = 1'b1;
            links_wa = u_b_ff;
            links_wd = '{next: head_ff, prev: NIL};
            head_in  = u_b_ff;
            state_in = ret_ff;
         end

         ST_TDONE: begin
            alu_a       = AW'({b_ff, 2'b00});
            alu_b       = AW'(HEADER_BYTES);
            res_addr_in = alu_res[ADDR_W-1:0];
            if (op_ff == OP_REALLOC) begin
               state_in = ST_COPY;
            end else begin
               state_in = ST_DONE;
            end
         end

         ST_COPY: begin
            alu_a       = AW'(oent_ff.size);
            alu_b       = AW'(HEADER_BYTES);
            alu_sub     = 1'b1;
            res_copy_in = alu_res[COPY_W-1:0];
            state_in    = ST_R_RD;
         end

         // A block is live when its offset lines up with a header that is busy.
         ST_LIVE: begin
            alu_a   = AW'(addr_ff);
            alu_b   = AW'(HEADER_BYTES);
            alu_sub = 1'b1;
            if (alu_res[AW-1] || alu_res[1:0] != 2'b00
                || alu_res[AW-1:2] >= (AW-2)'(DEPTH)) begin
               res_status_in = (op_ff == OP_REALLOC);
               state_in      = ST_DONE;
            end else begin
               old_in   = PW'(alu_res[AW-1:2]);
               phys_ra  = PW'(alu_res[AW-1:2]);
               state_in = ST_LCHK;
            end
         end

         ST_LCHK: begin
            if (!phys_rd.busy) begin
               res_status_in = (op_ff == OP_REALLOC);
               state_in      = ST_DONE;
            end else begin
               oent_in = phys_rd;
               if (op_ff == OP_FREE) begin
                  state_in = ST_R_RD;
               end else begin
                  state_in = ST_RCMP;
               end
            end
         end

         ST_RCMP: begin
            alu_a   = AW'(oent_ff.size);
            alu_b   = AW'(need_ff);
            alu_sub = 1'b1;
            if (!alu_res[AW-1]) begin
               res_addr_in = addr_ff;
               state_in    = ST_DONE;
            end else begin
               b_in     = head_ff;
               steps_in = '0;
               state_in = ST_WALK;
            end
         end

         // Release: re-read the block, since a split may have moved its back link.
         ST_R_RD: begin
            phys_ra  = old_ff;
            state_in = ST_R_ST;
         end

         ST_R_ST: begin
            cur_in  = old_ff;
            cent_in = '{size: phys_rd.size, busy: 1'b0, nphys: phys_rd.nphys,
                        pphys: phys_rd.pphys};
            phys_we = 1'b1;
            phys_wa = old_ff;
            phys_wd = cent_in;
            rn_in   = phys_rd.nphys;
            rp_in   = phys_rd.pphys;
            if (ptr_ok(phys_rd.pphys)) begin
               phys_ra  = phys_rd.pphys;
               state_in = ST_R_P;
            end else begin
               state_in = ST_R_N0;
            end
         end

         ST_R_P: begin
            if (!phys_rd.busy) begin
               alu_a    = AW'(phys_rd.size);
               alu_b    = AW'(cent_ff.size);
               cent_in  = '{size: alu_res[SW-1:0], busy: 1'b0, nphys: rn_ff,
                            pphys: phys_rd.pphys};
               cur_in   = rp_ff;
               phys_we  = 1'b1;
               phys_wa  = rp_ff;
               phys_wd  = cent_in;
               u_b_in   = rp_ff;
               ret_in   = ST_R_N0;
               state_in = ST_UL_RD;
            end else begin
               state_in = ST_R_N0;
            end
         end

         ST_R_N0: begin
            if (ptr_ok(rn_ff)) begin
               phys_ra  = rn_ff;
               state_in = ST_R_N;
            end else begin
               state_in = ST_R_PU;
            end
         end

         ST_R_N: begin
            phys_we = 1'b1;
            if (!phys_rd.busy) begin
               alu_a    = AW'(cent_ff.size);
               alu_b    = AW'(phys_rd.size);
               cent_in  = '{size: alu_res[SW-1:0], busy: 1'b0, nphys: phys_rd.nphys,
                            pphys: cent_ff.pphys};
               phys_wa  = cur_ff;
               phys_wd  = cent_in;
               rnn_in   = phys_rd.nphys;
               u_b_in   = rn_ff;
               ret_in   = ST_R_NN0;
               state_in = ST_UL_RD;
            end else begin
               phys_wa       = rn_ff;
               phys_wd       = phys_rd;
               phys_wd.pphys = cur_ff;
               state_in      = ST_R_PU;
            end
         end

         ST_R_NN0: begin
            if (ptr_ok(rnn_ff)) begin
               phys_ra  = rnn_ff;
               state_in = ST_R_NNW;
            end else begin
               state_in = ST_R_PU;
            end
         end

         ST_R_NNW: begin
            phys_we       = 1'b1;
            phys_wa       = rnn_ff;
            phys_wd       = phys_rd;
            phys_wd.pphys = cur_ff;
            state_in      = ST_R_PU;
         end

         ST_R_PU: begin
            u_b_in   = cur_ff;
            ret_in   = ST_DONE;
            state_in = ST_PU;
         end

         ST_CLR: begin
            phys_we  = 1'b1;
            phys_wa  = PW'(clr_ff);
            phys_wd  = '0;
            links_we = 1'b1;
            links_wa = PW'(clr_ff);
            links_wd = '{next: NIL, prev: NIL};
            clr_in   = clr_ff + IW'(1);
            if (clr_ff == IW'(DEPTH - 1)) begin
               state_in = ST_CLR_END;
            end
         end

         ST_CLR_END: begin
            phys_we  = 1'b1;
            phys_wa  = '0;
            phys_wd  = '{size: SW'(clr_sz), busy: 1'b0, nphys: NIL, pphys: NIL};
            head_in  = '0;
            state_in = ST_DONE;
         end

         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = res_addr_ff;
               rsp_status_in = res_status_ff;
               rsp_copy_in   = res_copy_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_copy_ff, rsp_status_ff, rsp_addr_ff};

`ifndef ASSERT_OFF
   a_head_range: assert property (@(posedge clock) disable iff (reset)
      head_ff <= NIL)
      else $error("free-list head holds an out-of-range index");

   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff |-> rsp_addr_ff == '0 && rsp_copy_ff == '0)
      else $error("failed response carries an address or copy count");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff != ST_IDLE)
      else $error("accepted transaction did not start the sequencer");

   a_phys_wr_range: assert property (@(posedge clock) disable iff (reset)
      phys_we |-> phys_wa < NIL)
      else $error("descriptor write to the null index");

   a_links_wr_range: assert property (@(posedge clock) disable iff (reset)
      links_we |-> links_wa < NIL)
      else $error("link write to the null index");
`endif

endmodule
